/* hdl/abrb_pkg.sv */
// Package: framebuffer geometry, field widths, codes and types of the blitter.
`default_nettype none
package abrb_pkg;

  localparam int FB_WIDTH    = 256;
  localparam int FB_HEIGHT   = 256;
  localparam int FB_DEPTH    = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W      = $clog2(FB_DEPTH);

  localparam int FUNC_W      = 2;
  localparam int POS_W       = 10;
  localparam int SIZE_W      = 9;
  localparam int CHAN_W      = 8;
  localparam int COORD_W     = 12;

  localparam int CLIP_POS_W  = 8;
  localparam int CLIP_SIZE_W = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  localparam int BLEND_SHIFT = 16;
  localparam int ONE_FIX     = 1 << BLEND_SHIFT;
  localparam int ALPHA_SCALE = ONE_FIX / 255;
  localparam int ALPHA_W     = BLEND_SHIFT;
  localparam int NALPHA_W    = BLEND_SHIFT + 1;
  localparam int MIX_W       = BLEND_SHIFT + CHAN_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FILL    = 2'd0,
    FUNC_OUTLINE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_ENABLE = 3'd0,
    CFG_CLIP_LEFT   = 3'd1,
    CFG_CLIP_TOP    = 3'd2,
    CFG_CLIP_WIDTH  = 3'd3,
    CFG_CLIP_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIP1,
    ST_CLIP2,
    ST_PREP,
    ST_FILL,
    ST_HORZ,
    ST_VERT,
    ST_READ,
    ST_RWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] r;
  } pixel_t;

endpackage
`default_nettype wire

/* hdl/abrb_ifs.sv */
// Interfaces: command channel and result channel of the blitter.
`default_nettype none
interface abrb_cmd_if;
  logic                                     valid;
  logic                                     ready;
  logic        [abrb_pkg::FUNC_W-1:0]       func;
  logic signed [abrb_pkg::POS_W-1:0]        pos_x;
  logic signed [abrb_pkg::POS_W-1:0]        pos_y;
  logic        [abrb_pkg::SIZE_W-1:0]       size_w;
  logic        [abrb_pkg::SIZE_W-1:0]       size_h;
  logic        [abrb_pkg::CHAN_W-1:0]       color_r;
  logic        [abrb_pkg::CHAN_W-1:0]       color_g;
  logic        [abrb_pkg::CHAN_W-1:0]       color_b;
  logic        [abrb_pkg::CHAN_W-1:0]       color_a;

  modport source (output valid, func, pos_x, pos_y, size_w, size_h,
                  color_r, color_g, color_b, color_a, input ready);
  modport sink   (input valid, func, pos_x, pos_y, size_w, size_h,
                  color_r, color_g, color_b, color_a, output ready);
endinterface

interface abrb_res_if;
  logic                          valid;
  logic                          ready;
  logic [abrb_pkg::CHAN_W-1:0]   pix_r;
  logic [abrb_pkg::CHAN_W-1:0]   pix_g;
  logic [abrb_pkg::CHAN_W-1:0]   pix_b;
  logic [abrb_pkg::CHAN_W-1:0]   pix_a;
  logic                          drawn;

  modport source (output valid, pix_r, pix_g, pix_b, pix_a, drawn, input ready);
  modport sink   (input valid, pix_r, pix_g, pix_b, pix_a, drawn, output ready);
endinterface
`default_nettype wire

/* hdl/alpha_blend_rect_blitter_top.sv */
// Top level: rectangle fill/outline blitter with read-modify-write framebuffer.
// Draw: setup states CLIP1, CLIP2, PREP, then one pixel slot a cycle over the clipped
//   rectangle (fill w*h, outline (h>1 ? 2w : w) + (w>1 ? 2h : h), none when empty); then
//   DONE posts the result word once the output is free, and IDLE takes the next command.
// Readback: READ, then RWAIT (skipped when out of range), then DONE posts the word.
// Reset: synchronous, active low; a clearing pass writes zero to all 65536 pixels first.
`default_nettype none
module alpha_blend_rect_blitter_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  abrb_cmd_if.sink                               in_ch,
  abrb_res_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [abrb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [abrb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import abrb_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] s,
                                            input logic [CHAN_W-1:0] d,
                                            input logic [ALPHA_W-1:0] a,
                                            input logic [NALPHA_W-1:0] na);
    logic [MIX_W-1:0] sum;
    sum = MIX_W'(s) * MIX_W'(a) + MIX_W'(d) * MIX_W'(na);
    return sum[BLEND_SHIFT +: CHAN_W];
  endfunction

  pixel_t fb_mem [FB_DEPTH];

  state_t                  state_r, state_nxt;
  logic                    clip_en_r;
  logic [CLIP_POS_W-1:0]   clip_left_r, clip_top_r;
  logic [CLIP_SIZE_W-1:0]  clip_width_r, clip_height_r;

  func_t                   func_r, func_nxt;
  coord_t                  x_r, x_nxt, y_r, y_nxt, w_r, w_nxt, h_r, h_nxt;
  coord_t                  xlast_r, xlast_nxt, ylast_r, ylast_nxt;
  pixel_t                  src_r, src_nxt;
  logic                    empty_r, empty_nxt;
  logic [SIZE_W-1:0]       wm1_r, wm1_nxt, hm1_r, hm1_nxt;
  logic [SIZE_W-1:0]       i_r, i_nxt, j_r, j_nxt;
  logic                    sub_r, sub_nxt;
  logic [ALPHA_W-1:0]      a_r, a_nxt;
  logic [NALPHA_W-1:0]     na_r, na_nxt;

  logic                    m_valid_r, m_valid_nxt;
  logic [ADDR_W-1:0]       m_addr_r, m_addr_nxt;
  logic                    m_fwd_r, m_fwd_nxt;
  pixel_t                  m_fwd_data_r, m_fwd_data_nxt;
  logic [ADDR_W-1:0]       clr_r, clr_nxt;
  pixel_t                  mem_q_r;

  pixel_t                  res_pix_r, res_pix_nxt;
  logic                    res_drawn_r, res_drawn_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pixel_t                  out_pix_r, out_pix_nxt;
  logic                    out_drawn_r, out_drawn_nxt;

  logic                    accept, out_free;
  coord_t                  wl, wt, wr, wb, cx, cy;
  logic                    in_fb, issue, draw_ok;
  logic                    last_i, last_j, fill_end, horz_end, vert_end, horz_step, vert_step;
  logic [ADDR_W-1:0]       pix_addr, wr_addr;
  logic                    wr_en;
  pixel_t                  dst, blend_word, wr_data;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.pix_r = out_pix_r.r;
  assign out_ch.pix_g = out_pix_r.g;
  assign out_ch.pix_b = out_pix_r.b;
  assign out_ch.pix_a = out_pix_r.a;
  assign out_ch.drawn = out_drawn_r;

  assign wl = coord_t'({1'b0, clip_left_r});
  assign wt = coord_t'({1'b0, clip_top_r});
  assign wr = wl + coord_t'({1'b0, clip_width_r});
  assign wb = wt + coord_t'({1'b0, clip_height_r});

  assign draw_ok   = !empty_r && (w_r > 0) && (h_r > 0);
  assign last_i    = (i_r == wm1_r);
  assign last_j    = (j_r == hm1_r);
  assign horz_step = sub_r || (hm1_r == '0);
  assign vert_step = sub_r || (wm1_r == '0);
  assign fill_end  = last_i && last_j;
  assign horz_end  = horz_step && last_i;
  assign vert_end  = vert_step && last_j;

  always_comb begin
    cx = x_r;
    cy = y_r;
    unique case (state_r)
      ST_FILL: begin
        cx = x_r + coord_t'({1'b0, i_r});
        cy = y_r + coord_t'({1'b0, j_r});
      end
      ST_HORZ: begin
        cx = x_r + coord_t'({1'b0, i_r});
        cy = sub_r ? ylast_r : y_r;
      end
      ST_VERT: begin
        cx = sub_r ? xlast_r : x_r;
        cy = y_r + coord_t'({1'b0, j_r});
      end
      default: begin
        cx = x_r;
        cy = y_r;
      end
    endcase
  end

  assign in_fb = !cx[COORD_W-1] && !cy[COORD_W-1] &&
                 (cx < COORD_W'(FB_WIDTH)) && (cy < COORD_W'(FB_HEIGHT));
  assign pix_addr = ADDR_W'(ADDR_W'(cy) * ADDR_W'(FB_WIDTH)) + ADDR_W'(cx);
  assign issue = in_fb &&
                 (state_r == ST_FILL || state_r == ST_HORZ || state_r == ST_VERT);

  assign dst          = m_fwd_r ? m_fwd_data_r : mem_q_r;
  assign blend_word.r = mix(src_r.r, dst.r, a_r, na_r);
  assign blend_word.g = mix(src_r.g, dst.g, a_r, na_r);
  assign blend_word.b = mix(src_r.b, dst.b, a_r, na_r);
  assign blend_word.a = src_r.a;

  assign wr_en   = (state_r == ST_CLEAR) || m_valid_r;
  assign wr_addr = (state_r == ST_CLEAR) ? clr_r : m_addr_r;
  assign wr_data = (state_r == ST_CLEAR) ? pixel_t'('0) : blend_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fb_mem[wr_addr] <= wr_data;
    end
    mem_q_r <= fb_mem[pix_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == ADDR_W'(FB_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_ch.func))
            FUNC_READ: state_nxt = ST_READ;
            FUNC_NONE: state_nxt = ST_DONE;
            default:   state_nxt = ST_CLIP1;
          endcase
        end
      end
      ST_CLIP1: state_nxt = ST_CLIP2;
      ST_CLIP2: state_nxt = ST_PREP;
      ST_PREP: begin
        priority if (!draw_ok)          state_nxt = ST_DONE;
        else if (func_r == FUNC_FILL)   state_nxt = ST_FILL;
        else                            state_nxt = ST_HORZ;
      end
      ST_FILL:  if (fill_end) state_nxt = ST_DONE;
      ST_HORZ:  if (horz_end) state_nxt = ST_VERT;
      ST_VERT:  if (vert_end) state_nxt = ST_DONE;
      ST_READ:  state_nxt = in_fb ? ST_RWAIT : ST_DONE;
      ST_RWAIT: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    func_nxt       = func_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    xlast_nxt      = xlast_r;
    ylast_nxt      = ylast_r;
    src_nxt        = src_r;
    empty_nxt      = empty_r;
    wm1_nxt        = wm1_r;
    hm1_nxt        = hm1_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    sub_nxt        = sub_r;
    a_nxt          = a_r;
    na_nxt         = na_r;
    clr_nxt        = clr_r;
    res_pix_nxt    = res_pix_r;
    res_drawn_nxt  = res_drawn_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_pix_nxt    = out_pix_r;
    out_drawn_nxt  = out_drawn_r;
    m_valid_nxt    = issue;
    m_addr_nxt     = pix_addr;
    m_fwd_nxt      = issue && m_valid_r && (pix_addr == m_addr_r);
    m_fwd_data_nxt = blend_word;

    unique case (state_r)
      ST_CLEAR: clr_nxt = clr_r + 1'b1;
      ST_IDLE: begin
        if (accept) begin
          func_nxt      = func_t'(in_ch.func);
          x_nxt         = coord_t'(in_ch.pos_x);
          y_nxt         = coord_t'(in_ch.pos_y);
          w_nxt         = coord_t'({1'b0, in_ch.size_w});
          h_nxt         = coord_t'({1'b0, in_ch.size_h});
          src_nxt       = '{a: in_ch.color_a, b: in_ch.color_b,
                            g: in_ch.color_g, r: in_ch.color_r};
          res_pix_nxt   = '0;
          res_drawn_nxt = 1'b0;
        end
      end
      ST_CLIP1: begin
        empty_nxt = 1'b0;
        if (clip_en_r) begin
          empty_nxt = (clip_width_r == '0) || (clip_height_r == '0);
          if (x_r < wl) begin
            w_nxt = w_r + x_r - wl;
            x_nxt = wl;
          end
          if (y_r < wt) begin
            h_nxt = h_r + y_r - wt;
            y_nxt = wt;
          end
        end
      end
      ST_CLIP2: begin
        if (clip_en_r) begin
          if (x_r + w_r > wr) w_nxt = wr - x_r;
          if (y_r + h_r > wb) h_nxt = wb - y_r;
        end
      end
      ST_PREP: begin
        xlast_nxt     = x_r + w_r - coord_t'(1);
        ylast_nxt     = y_r + h_r - coord_t'(1);
        wm1_nxt       = SIZE_W'(w_r - coord_t'(1));
        hm1_nxt       = SIZE_W'(h_r - coord_t'(1));
        a_nxt         = ALPHA_W'(32'(src_r.a) * ALPHA_SCALE);
        na_nxt        = NALPHA_W'(ONE_FIX) - NALPHA_W'(ALPHA_W'(32'(src_r.a) * ALPHA_SCALE));
        i_nxt         = '0;
        j_nxt         = '0;
        sub_nxt       = 1'b0;
        res_drawn_nxt = draw_ok;
      end
      ST_FILL: begin
        if (last_i) begin
          i_nxt = '0;
          j_nxt = j_r + 1'b1;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_HORZ: begin
        if (!horz_step) begin
          sub_nxt = 1'b1;
        end else begin
          sub_nxt = 1'b0;
          i_nxt   = last_i ? '0 : i_r + 1'b1;
        end
      end
      ST_VERT: begin
        if (!vert_step) begin
          sub_nxt = 1'b1;
        end else begin
          sub_nxt = 1'b0;
          j_nxt   = last_j ? '0 : j_r + 1'b1;
        end
      end
      ST_READ: ;
      ST_RWAIT: begin
        res_pix_nxt   = mem_q_r;
        res_drawn_nxt = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = res_pix_r;
          out_drawn_nxt = res_drawn_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      m_valid_r     <= 1'b0;
      m_fwd_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      clip_en_r     <= 1'b0;
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_width_r  <= CLIP_SIZE_W'(256);
      clip_height_r <= CLIP_SIZE_W'(256);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      m_valid_r   <= m_valid_nxt;
      m_fwd_r     <= m_fwd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLIP_ENABLE: clip_en_r     <= cfg_data[0];
          CFG_CLIP_LEFT:   clip_left_r   <= cfg_data[CLIP_POS_W-1:0];
          CFG_CLIP_TOP:    clip_top_r    <= cfg_data[CLIP_POS_W-1:0];
          CFG_CLIP_WIDTH:  clip_width_r  <= cfg_data[CLIP_SIZE_W-1:0];
          CFG_CLIP_HEIGHT: clip_height_r <= cfg_data[CLIP_SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    xlast_r      <= xlast_nxt;
    ylast_r      <= ylast_nxt;
    src_r        <= src_nxt;
    empty_r      <= empty_nxt;
    wm1_r        <= wm1_nxt;
    hm1_r        <= hm1_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    sub_r        <= sub_nxt;
    a_r          <= a_nxt;
    na_r         <= na_nxt;
    m_addr_r     <= m_addr_nxt;
    m_fwd_data_r <= m_fwd_data_nxt;
    res_pix_r    <= res_pix_nxt;
    res_drawn_r  <= res_drawn_nxt;
    out_pix_r    <= out_pix_nxt;
    out_drawn_r  <= out_drawn_nxt;
  end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the alpha-blend rectangle blitter: directed table, then random words.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import abrb_pkg::*;

  localparam int unsigned ALPHA_STEP = ONE_FIX / 255;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int IDLE_PCT = 37;

  typedef struct packed {
    logic                  wr;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    func_t                 func;
    logic [POS_W-1:0]      x;
    logic [POS_W-1:0]      y;
    logic [SIZE_W-1:0]     w;
    logic [SIZE_W-1:0]     h;
    pixel_t                color;
    logic                  known;
    pixel_t                px;
    logic                  drawn;
  } step_t;

  typedef struct packed {
    pixel_t px;
    logic   drawn;
  } reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  abrb_cmd_if in_ch();
  abrb_res_if out_ch();

  alpha_blend_rect_blitter_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pixel_t shadow_fb [FB_DEPTH];
  logic   clip_on;
  int     win_left, win_top, win_w, win_h;
  reply_t pending_replies [$];
  int     mismatches;
  int     words_seen;
  bit     calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void plot(int x, int y, pixel_t c);
    int unsigned a, na;
    pixel_t d;
    if (x < 0 || y < 0 || x >= FB_WIDTH || y >= FB_HEIGHT) return;
    d = shadow_fb[y * FB_WIDTH + x];
    a = c.a * ALPHA_STEP;
    na = ONE_FIX - a;
    d.r = 8'((c.r * a + d.r * na) >> BLEND_SHIFT);
    d.g = 8'((c.g * a + d.g * na) >> BLEND_SHIFT);
    d.b = 8'((c.b * a + d.b * na) >> BLEND_SHIFT);
    d.a = c.a;
    shadow_fb[y * FB_WIDTH + x] = d;
  endfunction

  function automatic reply_t apply_blit(step_t s);
    int x, y, w, h, right_edge, bottom_edge;
    reply_t rep;
    x = $signed(s.x);
    y = $signed(s.y);
    w = s.w;
    h = s.h;
    rep = '0;
    if (s.func == FUNC_READ) begin
      if (x >= 0 && y >= 0 && x < FB_WIDTH && y < FB_HEIGHT) begin
        rep.px = shadow_fb[y * FB_WIDTH + x];
        rep.drawn = 1'b1;
      end
      return rep;
    end
    if (s.func == FUNC_NONE) return rep;
    if (clip_on) begin
      if (win_w == 0 || win_h == 0) return rep;
      right_edge = win_left + win_w;
      bottom_edge = win_top + win_h;
      if (x < win_left) begin
        w -= win_left - x;
        x = win_left;
      end
      if (y < win_top) begin
        h -= win_top - y;
        y = win_top;
      end
      if (x + w > right_edge) w = right_edge - x;
      if (y + h > bottom_edge) h = bottom_edge - y;
    end
    if (w <= 0 || h <= 0) return rep;
    if (s.func == FUNC_FILL) begin
      for (int j = 0; j < h; j++)
        for (int i = 0; i < w; i++) plot(x + i, y + j, s.color);
    end else begin
      for (int i = 0; i < w; i++) begin
        plot(x + i, y, s.color);
        if (h > 1) plot(x + i, y + h - 1, s.color);
      end
      for (int j = 0; j < h; j++) begin
        plot(x, y + j, s.color);
        if (w > 1) plot(x + w - 1, y + j, s.color);
      end
    end
    rep.drawn = 1'b1;
    return rep;
  endfunction

  function automatic step_t reg_row(cfg_idx_t idx, int v);
    step_t s;
    s = '0;
    s.wr = 1'b1;
    s.idx = idx;
    s.data = v[CFG_DATA_W-1:0];
    return s;
  endfunction

  function automatic step_t cmd_row(func_t f, int x, int y, int w, int h, logic [31:0] c);
    step_t s;
    s = '0;
    s.func = f;
    s.x = x[POS_W-1:0];
    s.y = y[POS_W-1:0];
    s.w = w[SIZE_W-1:0];
    s.h = h[SIZE_W-1:0];
    s.color = c;
    return s;
  endfunction

  function automatic step_t known_row(func_t f, int x, int y, int w, int h, logic [31:0] c,
                                      logic [31:0] px, logic drawn);
    step_t s;
    s = cmd_row(f, x, y, w, h, c);
    s.known = 1'b1;
    s.px = px;
    s.drawn = drawn;
    return s;
  endfunction

  function automatic logic [POS_W-1:0] coord(int lo, int hi);
    int v;
    v = lo + int'($urandom_range(hi - lo));
    return v[POS_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] clip_corner();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 25) return CFG_DATA_W'(255);
    return CFG_DATA_W'($urandom_range(48));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] clip_span();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 25) return CFG_DATA_W'(256);
    if (pick < 80) return CFG_DATA_W'($urandom_range(64, 1));
    return CFG_DATA_W'($urandom_range(256));
  endfunction

  task automatic note_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      CFG_CLIP_ENABLE: clip_on = v[0];
      CFG_CLIP_LEFT:   win_left = int'(v[CLIP_POS_W-1:0]);
      CFG_CLIP_TOP:    win_top = int'(v[CLIP_POS_W-1:0]);
      CFG_CLIP_WIDTH:  win_w = int'(v);
      CFG_CLIP_HEIGHT: win_h = int'(v);
      default: ;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send(step_t s);
    reply_t rep;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= s.func;
    in_ch.pos_x <= s.x;
    in_ch.pos_y <= s.y;
    in_ch.size_w <= s.w;
    in_ch.size_h <= s.h;
    in_ch.color_r <= s.color.r;
    in_ch.color_g <= s.color.g;
    in_ch.color_b <= s.color.b;
    in_ch.color_a <= s.color.a;
    do @(posedge clk); while (!in_ch.ready);
    rep = apply_blit(s);
    if (s.known) begin
      rep.px = s.px;
      rep.drawn = s.drawn;
    end
    pending_replies.push_back(rep);
  endtask

  initial begin
    reply_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        words_seen++;
        if (pending_replies.size() == 0) begin
          note_mismatch($sformatf("word %0d arrived with nothing pending", words_seen));
        end else begin
          want = pending_replies.pop_front();
          if (out_ch.pix_r !== want.px.r || out_ch.pix_g !== want.px.g ||
              out_ch.pix_b !== want.px.b || out_ch.pix_a !== want.px.a ||
              out_ch.drawn !== want.drawn)
            note_mismatch($sformatf("word %0d got %02h%02h%02h%02h/%b want %08h/%b",
                                    words_seen, out_ch.pix_a, out_ch.pix_b, out_ch.pix_g,
                                    out_ch.pix_r, out_ch.drawn, want.px, want.drawn));
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #200_000_000;
    $display("[alpha_blend_rect_blitter_top] ERROR");
    $finish;
  end

  initial begin
    step_t plan [$];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_FILL;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.size_w <= '0;
    in_ch.size_h <= '0;
    in_ch.color_r <= '0;
    in_ch.color_g <= '0;
    in_ch.color_b <= '0;
    in_ch.color_a <= '0;
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    clip_on = 1'b0;
    win_left = 0;
    win_top = 0;
    win_w = FB_WIDTH;
    win_h = FB_HEIGHT;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    plan = '{
      known_row(FUNC_READ,       0,    0,   0,   0, 32'h0,        32'h0, 1'b1),
      known_row(FUNC_READ,     255,  255, 511, 511, 32'hFFFFFFFF, 32'h0, 1'b1),
      known_row(FUNC_READ,    -512, -512,   0,   0, 32'h0,        32'h0, 1'b0),
      known_row(FUNC_READ,     511,  511,   0,   0, 32'h0,        32'h0, 1'b0),
      known_row(FUNC_READ,     256,   -1,   0,   0, 32'h0,        32'h0, 1'b0),
      known_row(FUNC_NONE,      10,   10,  20,  20, 32'hFFFFFFFF, 32'h0, 1'b0),
      known_row(FUNC_FILL,       0,    0,   0,   5, 32'hFFFFFFFF, 32'h0, 1'b0),
      known_row(FUNC_OUTLINE,    0,    0,   7,   0, 32'hFFFFFFFF, 32'h0, 1'b0),
      cmd_row(FUNC_FILL,         0,    0,   4,   3, 32'hFF336699),
      cmd_row(FUNC_OUTLINE,      2,    1,   5,   4, 32'h80FF00C0),
      cmd_row(FUNC_OUTLINE,      3,    2,   1,   1, 32'h40102030),
      cmd_row(FUNC_OUTLINE,      8,    0,   1,   5, 32'hC0A0B0C0),
      cmd_row(FUNC_OUTLINE,      0,    4,   6,   1, 32'h7F0F1F2F),
      cmd_row(FUNC_FILL,        -3,   -2,   6,   5, 32'h00FFFFFF),
      cmd_row(FUNC_FILL,       250,  252, 511,   8, 32'hFFFFFFFF),
      known_row(FUNC_OUTLINE, -512, -512, 511, 511, 32'hFFFFFFFF, 32'h0, 1'b1),
      cmd_row(FUNC_READ,       255,  255,   0,   0, 32'h0),
      reg_row(CFG_CLIP_ENABLE, 1),
      reg_row(CFG_CLIP_LEFT, 2),
      reg_row(CFG_CLIP_TOP, 1),
      reg_row(CFG_CLIP_WIDTH, 3),
      reg_row(CFG_CLIP_HEIGHT, 4),
      cmd_row(FUNC_FILL,         0,    0, 511, 511, 32'h8040C0FF),
      known_row(FUNC_OUTLINE, -512, -512, 511, 511, 32'hFFFFFFFF, 32'h0, 1'b0),
      cmd_row(FUNC_OUTLINE,      1,    0,  10,  10, 32'hA0123456),
      known_row(FUNC_READ,      -1,    3,   0,   0, 32'h0,        32'h0, 1'b0),
      known_row(FUNC_READ,     200,  200,   0,   0, 32'h0,        32'h0, 1'b1),
      reg_row(CFG_CLIP_WIDTH, 0),
      known_row(FUNC_FILL,       2,    1,   3,   3, 32'hFFFFFFFF, 32'h0, 1'b0),
      reg_row(CFG_CLIP_WIDTH, 256),
      reg_row(CFG_CLIP_HEIGHT, 0),
      known_row(FUNC_OUTLINE,    2,    1,   3,   3, 32'hFFFFFFFF, 32'h0, 1'b0),
      reg_row(CFG_CLIP_LEFT, 255),
      reg_row(CFG_CLIP_TOP, 255),
      reg_row(CFG_CLIP_HEIGHT, 256),
      cmd_row(FUNC_FILL,       250,  250,  10,  10, 32'h99AABBCC),
      cmd_row(FUNC_READ,       255,  255,   0,   0, 32'h0)
    };

    for (int k = 0; k < plan.size(); k++) begin
      if (plan[k].wr) begin
        if (k > 0 && !plan[k-1].wr) drain();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        if (k > 0 && plan[k-1].wr) cfg_we <= 1'b0;
        send(plan[k]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      calm = (p == 3);
      write_reg(CFG_CLIP_ENABLE, (p != 0 && $urandom_range(9) < 7) ? 9'd1 : 9'd0);
      write_reg(CFG_CLIP_LEFT, clip_corner());
      write_reg(CFG_CLIP_TOP, clip_corner());
      write_reg(CFG_CLIP_WIDTH, clip_span());
      write_reg(CFG_CLIP_HEIGHT, clip_span());
      cfg_we <= 1'b0;
      repeat (ITEMS_PER_PHASE) begin
        step_t s;
        int unsigned pick;
        s = '0;
        pick = $urandom_range(99);
        if (pick < 40) s.func = FUNC_FILL;
        else if (pick < 65) s.func = FUNC_OUTLINE;
        else if (pick < 95) s.func = FUNC_READ;
        else s.func = FUNC_NONE;
        pick = $urandom_range(99);
        if (pick < 60) begin
          s.x = coord(-4, 40);
          s.y = coord(-4, 40);
        end else if (pick < 85) begin
          s.x = coord(-8, 263);
          s.y = coord(-8, 263);
        end else begin
          s.x = POS_W'($urandom);
          s.y = POS_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 85) begin
          s.w = SIZE_W'($urandom_range(12));
          s.h = SIZE_W'($urandom_range(12));
        end else if (pick < 97) begin
          s.w = SIZE_W'($urandom_range(40));
          s.h = SIZE_W'($urandom_range(40));
        end else begin
          s.w = SIZE_W'($urandom_range(511));
          s.h = (s.func == FUNC_FILL) ? SIZE_W'($urandom_range(8))
                                      : SIZE_W'($urandom_range(511));
          if ($urandom_range(1) == 1) {s.w, s.h} = {s.h, s.w};
        end
        s.color = $urandom;
        pick = $urandom_range(99);
        if (pick < 10) s.color.a = '0;
        else if (pick < 20) s.color.a = '1;
        send(s);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("[alpha_blend_rect_blitter_top] OK");
    else
      $display("[alpha_blend_rect_blitter_top] ERROR");
    $finish;
  end

endmodule

/* files.f */
hdl/abrb_pkg.sv
hdl/abrb_ifs.sv
hdl/alpha_blend_rect_blitter_top.sv
sim/tb_top.sv
